// ===== src/mme_pkg.sv =====
// Types, constants and helper functions shared by the matrix multiply engine.
package mme_pkg;

    localparam int MAX_DIM    = 8;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DATA_WIDTH = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int ACC_W      = 40;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;
    localparam logic [CFG_W-1:0]     CFG_RESET     = 4'd8;

    typedef struct packed {
        logic                         cmd;
        logic [IDX_W-1:0]             row;
        logic [IDX_W-1:0]             col;
        logic signed [DATA_WIDTH-1:0] value;
        logic                         start_req;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [ACC_W-1:0] product_value;
        logic                    last;
    } t_out_item;

    typedef enum logic {
        OP_LOAD_A = 1'b0,
        OP_LOAD_B = 1'b1
    } t_op;

    typedef struct packed {
        t_op                          op;
        logic [ADDR_W-1:0]            addr;
        logic signed [DATA_WIDTH-1:0] value;
        logic                         start;
    } t_qentry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Effective sizes, held as the size minus one.
    typedef struct packed {
        logic [IDX_W-1:0] rows_m1;
        logic [IDX_W-1:0] inner_m1;
        logic [IDX_W-1:0] cols_m1;
    } t_dims;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } t_back_state;

    // A size of zero acts as one, and a size above the store acts as the store size.
    function automatic logic [IDX_W-1:0] eff_dim_m1(input logic [CFG_W-1:0] raw);
        logic [IDX_W-1:0] res;
        if (raw == '0) begin
            res = '0;
        end else if (raw > CFG_W'(MAX_DIM)) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(raw - CFG_W'(1));
        end
        return res;
    endfunction

endpackage

// ===== src/mme_front.sv =====
// Front end: registers each incoming request, classifies it and pushes it into the queue.
module mme_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mme_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    input  mme_pkg::t_q_status i_q_status,
    output logic               o_push,
    output mme_pkg::t_qentry   o_entry
);
    import mme_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_qentry r_entry;
    logic    accept;

    assign o_in_stall = r_valid && i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_status.full;
    assign o_entry    = r_entry;

    always_comb begin
        n_valid = accept || (r_valid && i_q_status.full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry.op    <= i_in_item.cmd ? OP_LOAD_B : OP_LOAD_A;
            r_entry.addr  <= {i_in_item.row, i_in_item.col};
            r_entry.value <= i_in_item.value;
            r_entry.start <= i_in_item.start_req;
        end
    end

endmodule

// ===== src/mme_queue.sv =====
// Short request queue between the front end and the multiply back end.
module mme_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mme_pkg::t_qentry   i_entry,
    input  logic               i_pop,
    output mme_pkg::t_qentry   o_head,
    output mme_pkg::t_q_status o_status
);
    import mme_pkg::*;

    t_qentry           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== src/mme_back.sv =====
// Back end: element stores, the single multiply-accumulate pipeline and the result register.
module mme_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mme_pkg::t_dims     i_dims,
    input  mme_pkg::t_qentry   i_head,
    input  mme_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_out_valid,
    output mme_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import mme_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_a_mem [MAX_DIM*MAX_DIM];
    logic signed [DATA_WIDTH-1:0] r_b_mem [MAX_DIM*MAX_DIM];
    logic signed [DATA_WIDTH-1:0] r_a_q;
    logic signed [DATA_WIDTH-1:0] r_b_q;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [ACC_W-1:0]      r_acc;

    t_back_state      r_state, n_state;
    t_dims            r_dims, n_dims;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    logic             r_v1, r_v2;
    logic             r_first1, r_first2;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_item;

    logic              issue;
    logic              out_load;
    logic              out_free;
    logic              elem_last;
    logic [ADDR_W-1:0] a_rd_addr;
    logic [ADDR_W-1:0] b_rd_addr;

    assign a_rd_addr   = {r_i, r_k};
    assign b_rd_addr   = {r_k, r_j};
    assign out_free    = !r_out_valid || !i_out_stall;
    assign elem_last   = (r_i == r_dims.rows_m1) && (r_j == r_dims.cols_m1);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_state  = r_state;
        n_dims   = r_dims;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        o_pop    = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    if (i_head.start) begin
                        n_dims  = i_dims;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                issue = 1'b1;
                if (r_k == r_dims.inner_m1) begin
                    n_k     = '0;
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_WAIT: begin
                // The sum is complete once both pipeline stages have drained.
                if (!r_v1 && !r_v2 && out_free) begin
                    out_load = 1'b1;
                    if (elem_last) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_IDLE;
                    end else begin
                        if (r_j == r_dims.cols_m1) begin
                            n_j = '0;
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_j = r_j + IDX_W'(1);
                        end
                        n_state = S_ISSUE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = out_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dims      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dims      <= n_dims;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_v1        <= issue;
            r_v2        <= r_v1;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.op == OP_LOAD_A) begin
            r_a_mem[i_head.addr] <= i_head.value;
        end
        r_a_q <= r_a_mem[a_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.op == OP_LOAD_B) begin
            r_b_mem[i_head.addr] <= i_head.value;
        end
        r_b_q <= r_b_mem[b_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_k == '0);
        r_first2 <= r_first1;
        r_prod   <= r_a_q * r_b_q;
        if (r_v2) begin
            r_acc <= r_first2 ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
        if (out_load) begin
            r_out_item.out_row       <= r_i;
            r_out_item.out_col       <= r_j;
            r_out_item.product_value <= r_acc;
            r_out_item.last          <= elem_last;
        end
    end

endmodule

// ===== src/matrix_multiply_engine.sv =====
// Top level of the fixed-point matrix multiply engine: size registers and the three parts.
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     i_in_item  (t_in_item)
//  result    out        o_out_valid / i_out_stall   o_out_item (t_out_item)
//  config    in         i_cfg_wr_en                 i_cfg_index, i_cfg_wdata
//
// Load requests are taken one per cycle while o_in_stall is low; a four-entry queue lets
// loading run ahead of the multiply unit. Each result is formed by the single
// multiply-accumulate pipeline (store read, multiply, accumulate, result register), and a
// start request keeps the back end busy until all rows_a * cols_b results have been loaded.
// Reset is synchronous; it clears control state and sets all three sizes to eight.
// The element stores hold whatever they held until written. A stalled result holds the
// back end in place while the front end keeps filling the queue.
module matrix_multiply_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  mme_pkg::t_in_item                 i_in_item,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output mme_pkg::t_out_item                o_out_item,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_wr_en,
    input  logic [mme_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import mme_pkg::*;

    logic [CFG_W-1:0] r_rows_a;
    logic [CFG_W-1:0] r_inner_len;
    logic [CFG_W-1:0] r_cols_b;
    t_dims            dims;
    t_q_status        q_status;
    t_qentry          push_entry;
    t_qentry          head;
    logic             push;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= CFG_RESET;
            r_inner_len <= CFG_RESET;
            r_cols_b    <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_wdata;
                CFG_INNER_LEN: r_inner_len <= i_cfg_wdata;
                CFG_COLS_B:    r_cols_b    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign dims.rows_m1  = eff_dim_m1(r_rows_a);
    assign dims.inner_m1 = eff_dim_m1(r_inner_len);
    assign dims.cols_m1  = eff_dim_m1(r_cols_b);

    mme_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    mme_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    mme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (dims),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== src/mme_checker.sv =====
// Port-level checks on the matrix multiply engine, bound to its top level.
module mme_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input mme_pkg::t_in_item             i_in_item,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input mme_pkg::t_out_item            o_out_item,
    input logic                          i_out_stall,
    input logic                          i_cfg_wr_en,
    input logic [mme_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [mme_pkg::CFG_W-1:0]     i_cfg_wdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("result payload changed while stalled");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result request present after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled straight after reset");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

// ===== sim/tb_matrix_multiply_engine.sv =====
// Self-checking testbench for the fixed-point matrix multiply engine.
`timescale 1ns / 1ps

module tb_matrix_multiply_engine;

    import mme_pkg::*;

    localparam int RANDOM_REQUESTS = 330;
    localparam int DRAIN_CYCLES    = 24;
    localparam int ELEMS           = MAX_DIM * MAX_DIM;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_value;
        t_in_item             req;
        bit                   has_known;
        t_out_item            known_result;
    } t_step;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_item   = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_item            out_item;
    logic                 out_stall = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Expected product written into the table, travelling alongside its request.
    logic                 req_has_known = 1'b0;
    t_out_item            req_known     = '0;

    // Predictor state: element stores and size registers as the engine should hold them.
    logic signed [DATA_WIDTH-1:0] a_elem [ELEMS];
    logic signed [DATA_WIDTH-1:0] b_elem [ELEMS];
    logic [CFG_W-1:0]             size_rows  = CFG_RESET;
    logic [CFG_W-1:0]             size_inner = CFG_RESET;
    logic [CFG_W-1:0]             size_cols  = CFG_RESET;
    t_out_item                    expected_products [$];

    // Elements written so far, as seen by the request generator.
    bit a_loaded [ELEMS];
    bit b_loaded [ELEMS];

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int failures        = 0;
    int requests_sent   = 0;
    int starts_seen     = 0;
    int results_checked = 0;
    int reg_writes      = 0;

    matrix_multiply_engine uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic int eff_size(input logic [CFG_W-1:0] raw);
        if (raw == '0) begin
            return 1;
        end
        if (int'(raw) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(raw);
    endfunction

    // Stores the element, and on a start request works out every product in row-major order.
    task automatic predict_request(input t_in_item r, input bit keep);
        int        nr;
        int        nk;
        int        nc;
        longint    acc;
        t_out_item res;
        if (r.cmd == OP_LOAD_A) begin
            a_elem[{r.row, r.col}] = r.value;
        end else begin
            b_elem[{r.row, r.col}] = r.value;
        end
        if (r.start_req) begin
            nr = eff_size(size_rows);
            nk = eff_size(size_inner);
            nc = eff_size(size_cols);
            starts_seen++;
            for (int i = 0; i < nr; i++) begin
                for (int j = 0; j < nc; j++) begin
                    acc = 0;
                    for (int k = 0; k < nk; k++) begin
                        acc += longint'(a_elem[i * MAX_DIM + k]) *
                               longint'(b_elem[k * MAX_DIM + j]);
                    end
                    res.out_row       = IDX_W'(i);
                    res.out_col       = IDX_W'(j);
                    res.product_value = ACC_W'(acc);
                    res.last          = (i == nr - 1) && (j == nc - 1);
                    if (keep) begin
                        expected_products.push_back(res);
                    end
                end
            end
        end
    endtask

    always @(posedge clk) begin : product_monitor
        t_out_item want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_request(in_item, !req_has_known);
                if (req_has_known) begin
                    expected_products.push_back(req_known);
                end
            end
            if (out_valid && !out_stall) begin
                if (expected_products.size() == 0) begin
                    $error("product at row %0d col %0d with none expected",
                           out_item.out_row, out_item.out_col);
                    failures++;
                end else begin
                    want = expected_products.pop_front();
                    results_checked++;
                    if (out_item.out_row !== want.out_row) begin
                        $error("out_row: expected %0d, got %0d", want.out_row, out_item.out_row);
                        failures++;
                    end
                    if (out_item.out_col !== want.out_col) begin
                        $error("out_col: expected %0d, got %0d", want.out_col, out_item.out_col);
                        failures++;
                    end
                    if (out_item.product_value !== want.product_value) begin
                        $error("product_value: expected %0d, got %0d",
                               want.product_value, out_item.product_value);
                        failures++;
                    end
                    if (out_item.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, out_item.last);
                        failures++;
                    end
                end
            end
        end
    end

    task automatic send_request(input t_in_item r, input bit has_known,
                                input t_out_item known_result);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        in_item       <= r;
        req_has_known <= has_known;
        req_known     <= known_result;
        if (r.cmd == OP_LOAD_A) begin
            a_loaded[{r.row, r.col}] = 1'b1;
        end else begin
            b_loaded[{r.row, r.col}] = 1'b1;
        end
        requests_sent++;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Holds requests back until every product has come and the load queue has emptied.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_products.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (index)
            CFG_ROWS_A:    size_rows  = value;
            CFG_INNER_LEN: size_inner = value;
            CFG_COLS_B:    size_cols  = value;
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] rand_value();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return '1;
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_request();
        t_in_item r;
        r.cmd       = 1'($urandom_range(1));
        r.row       = IDX_W'($urandom_range(MAX_DIM - 1));
        r.col       = IDX_W'($urandom_range(MAX_DIM - 1));
        r.value     = rand_value();
        r.start_req = 1'b0;
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] rand_size();
        case ($urandom_range(11))
            0:       return '0;
            1:       return CFG_W'(MAX_DIM);
            2:       return CFG_W'($urandom_range(MAX_DIM + 1, 15));
            default: return CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Loads every element the current sizes need that is not yet held, reloads some others,
    // mixes in stray loads, and marks the final request as the start.
    task automatic run_matrix();
        t_in_item plan [$];
        t_in_item r;
        t_in_item tmp;
        int       nr;
        int       nk;
        int       nc;
        int       reload_pct;
        int       pick;
        int       last_n;
        bit       all_known;
        nr = eff_size(size_rows);
        nk = eff_size(size_inner);
        nc = eff_size(size_cols);
        reload_pct = (nr * nk + nk * nc > 16) ? 8 : 40;
        all_known = 1'b1;
        r.start_req = 1'b0;
        for (int i = 0; i < nr; i++) begin
            for (int k = 0; k < nk; k++) begin
                if (!a_loaded[i * MAX_DIM + k]) begin
                    all_known = 1'b0;
                end
                if (!a_loaded[i * MAX_DIM + k] || $urandom_range(99) < reload_pct) begin
                    r.cmd   = OP_LOAD_A;
                    r.row   = IDX_W'(i);
                    r.col   = IDX_W'(k);
                    r.value = rand_value();
                    plan.push_back(r);
                end
            end
        end
        for (int k = 0; k < nk; k++) begin
            for (int j = 0; j < nc; j++) begin
                if (!b_loaded[k * MAX_DIM + j]) begin
                    all_known = 1'b0;
                end
                if (!b_loaded[k * MAX_DIM + j] || $urandom_range(99) < reload_pct) begin
                    r.cmd   = OP_LOAD_B;
                    r.row   = IDX_W'(k);
                    r.col   = IDX_W'(j);
                    r.value = rand_value();
                    plan.push_back(r);
                end
            end
        end
        repeat ($urandom_range(2)) plan.push_back(rand_request());
        for (int n = plan.size() - 1; n > 0; n--) begin
            pick       = $urandom_range(n);
            tmp        = plan[n];
            plan[n]    = plan[pick];
            plan[pick] = tmp;
        end
        if (plan.size() == 0) begin
            plan.push_back(rand_request());
        end
        last_n = plan.size() - 1;
        // With every needed element already held, the start may cut a reload short.
        if (all_known && $urandom_range(3) == 0) begin
            last_n = $urandom_range(last_n);
        end
        plan[last_n].start_req = 1'b1;
        for (int n = 0; n <= last_n; n++) begin
            send_request(plan[n], 1'b0, '0);
        end
    endtask

    function automatic t_step load_step(input t_op op, input int row, input int col,
                                        input int value, input bit start);
        t_step s;
        s.is_reg        = 1'b0;
        s.reg_index     = '0;
        s.reg_value     = '0;
        s.req.cmd       = op;
        s.req.row       = IDX_W'(row);
        s.req.col       = IDX_W'(col);
        s.req.value     = DATA_WIDTH'(value);
        s.req.start_req = start;
        s.has_known     = 1'b0;
        s.known_result  = '0;
        return s;
    endfunction

    // A start on a one-by-one product whose value is written straight into the table.
    function automatic t_step known_step(input t_op op, input int row, input int col,
                                         input int value, input longint product);
        t_step s;
        s = load_step(op, row, col, value, 1'b1);
        s.has_known                  = 1'b1;
        s.known_result.out_row       = '0;
        s.known_result.out_col       = '0;
        s.known_result.product_value = ACC_W'(product);
        s.known_result.last          = 1'b1;
        return s;
    endfunction

    function automatic t_step reg_step(input logic [CFG_IDX_W-1:0] index,
                                       input logic [CFG_W-1:0] value);
        t_step s;
        s           = load_step(OP_LOAD_A, 0, 0, 0, 1'b0);
        s.is_reg    = 1'b1;
        s.reg_index = index;
        s.reg_value = value;
        return s;
    endfunction

    initial begin : limit_guard
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        t_step directed [$];
        int    column_values [MAX_DIM] = '{32767, -32768, 0, -1, 1, 16384, -21846, 12345};
        int    directed_sent;
        int    phase;
        int    n_mats;

        // Rows keep their reset size of eight; a single B element scales one column of A.
        directed.push_back(reg_step(CFG_INNER_LEN, 4'd1));
        directed.push_back(reg_step(CFG_COLS_B, 4'd1));
        directed.push_back(load_step(OP_LOAD_B, 0, 0, -32768, 1'b0));
        for (int r = 0; r < MAX_DIM; r++) begin
            directed.push_back(load_step(OP_LOAD_A, r, 0, column_values[r], r == MAX_DIM - 1));
        end
        directed.push_back(reg_step(CFG_ROWS_A, 4'd1));
        directed.push_back(known_step(OP_LOAD_A, 0, 0, -32768, 64'sd1073741824));
        directed.push_back(known_step(OP_LOAD_B, 0, 0, 32767, -64'sd1073709056));
        // Zero sizes behave as one.
        directed.push_back(reg_step(CFG_ROWS_A, 4'd0));
        directed.push_back(reg_step(CFG_INNER_LEN, 4'd0));
        directed.push_back(reg_step(CFG_COLS_B, 4'd0));
        directed.push_back(known_step(OP_LOAD_A, 0, 0, 0, 64'sd0));
        directed.push_back(load_step(OP_LOAD_A, 7, 7, 32767, 1'b0));
        directed.push_back(known_step(OP_LOAD_B, 7, 7, -1, 64'sd0));
        directed.push_back(known_step(OP_LOAD_A, 0, 0, -1, -64'sd32767));
        directed.push_back(known_step(OP_LOAD_B, 0, 0, -32768, 64'sd32768));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n]) begin
            if (directed[n].is_reg) begin
                wait_drained();
                write_reg(directed[n].reg_index, directed[n].reg_value);
            end else begin
                send_request(directed[n].req, directed[n].has_known, directed[n].known_result);
            end
        end
        directed_sent = requests_sent;

        phase = 0;
        while (requests_sent < directed_sent + RANDOM_REQUESTS) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            wait_drained();
            if (phase == 1) begin
                // Full eight by eight by eight: fills both stores and gives the most products.
                write_reg(CFG_ROWS_A, CFG_W'(MAX_DIM));
                write_reg(CFG_INNER_LEN, CFG_W'(MAX_DIM));
                write_reg(CFG_COLS_B, CFG_W'(MAX_DIM));
            end else if (phase == 3) begin
                write_reg(CFG_ROWS_A, 4'd15);
                write_reg(CFG_INNER_LEN, 4'd9);
                write_reg(CFG_COLS_B, 4'd0);
            end else begin
                write_reg(CFG_ROWS_A, rand_size());
                write_reg(CFG_INNER_LEN, rand_size());
                write_reg(CFG_COLS_B, rand_size());
            end
            n_mats = (phase == 1) ? 1 : $urandom_range(2, 4);
            for (int m = 0; m < n_mats; m++) begin
                run_matrix();
                if ((phase == 0 && m == 0) || $urandom_range(9) < 2) begin
                    wait_drained();
                end
            end
            phase++;
        end

        wait_drained();
        $display("Run covered %0d load requests with %0d starts over %0d register writes,",
                 requests_sent, starts_seen, reg_writes);
        $display("and compared %0d products under four idling patterns.", results_checked);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/mme_pkg.sv
src/mme_front.sv
src/mme_queue.sv
src/mme_back.sv
src/matrix_multiply_engine.sv
src/mme_checker.sv
sim/tb_matrix_multiply_engine.sv
